>>> design/hdlf_pkg.sv
// Shared types and constant tables for the H.264 deblocking line filter.
// Used by hdlf_core and h264_deblock_line_filter; depends on nothing else.
package hdlf_pkg;

  localparam int QP_MAX = 51;
  localparam int NUM_IDX = QP_MAX + 1;

  // Configuration register indexes.
  localparam logic CFG_ALPHA_ADJ = 1'b0;
  localparam logic CFG_BETA_ADJ  = 1'b1;

  localparam int BS_STRONG = 4;

  typedef struct packed {
    logic [7:0] p3;
    logic [7:0] p2;
    logic [7:0] p1;
    logic [7:0] p0;
    logic [7:0] q0;
    logic [7:0] q1;
    logic [7:0] q2;
    logic [7:0] q3;
    logic [2:0] bs;
    logic [5:0] qp_p;
    logic [5:0] qp_q;
    logic       is_chroma;
  } line_t;

  typedef struct packed {
    logic [7:0] p2;
    logic [7:0] p1;
    logic [7:0] p0;
    logic [7:0] q0;
    logic [7:0] q1;
    logic [7:0] q2;
    logic       filtered;
  } result_t;

  localparam logic [7:0] ALPHA_TAB [NUM_IDX] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd4, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
    8'd12, 8'd13, 8'd15, 8'd17, 8'd20, 8'd22, 8'd25, 8'd28,
    8'd32, 8'd36, 8'd40, 8'd45, 8'd50, 8'd56, 8'd63, 8'd71,
    8'd80, 8'd90, 8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182,
    8'd203, 8'd226, 8'd255, 8'd255
  };

  localparam logic [4:0] BETA_TAB [NUM_IDX] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3, 5'd4,
    5'd4, 5'd4, 5'd6, 5'd6, 5'd7, 5'd7, 5'd8, 5'd8,
    5'd9, 5'd9, 5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12,
    5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16,
    5'd17, 5'd17, 5'd18, 5'd18
  };

  localparam logic [4:0] TC0_TAB [NUM_IDX][3] = '{
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd1}, '{5'd0, 5'd0, 5'd1}, '{5'd0, 5'd0, 5'd1},
    '{5'd0, 5'd0, 5'd1}, '{5'd0, 5'd1, 5'd1}, '{5'd0, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd1},
    '{5'd1, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd2},
    '{5'd1, 5'd1, 5'd2}, '{5'd1, 5'd1, 5'd2}, '{5'd1, 5'd1, 5'd2}, '{5'd1, 5'd2, 5'd3},
    '{5'd1, 5'd2, 5'd3}, '{5'd2, 5'd2, 5'd3}, '{5'd2, 5'd2, 5'd4}, '{5'd2, 5'd3, 5'd4},
    '{5'd2, 5'd3, 5'd4}, '{5'd3, 5'd3, 5'd5}, '{5'd3, 5'd4, 5'd6}, '{5'd3, 5'd4, 5'd6},
    '{5'd4, 5'd5, 5'd7}, '{5'd4, 5'd5, 5'd8}, '{5'd4, 5'd6, 5'd9}, '{5'd5, 5'd7, 5'd10},
    '{5'd6, 5'd8, 5'd11}, '{5'd6, 5'd8, 5'd13}, '{5'd7, 5'd10, 5'd14}, '{5'd8, 5'd11, 5'd16},
    '{5'd9, 5'd12, 5'd18}, '{5'd10, 5'd13, 5'd20}, '{5'd11, 5'd15, 5'd23},
    '{5'd13, 5'd17, 5'd25}
  };

endpackage

>>> design/hdlf_core.sv
// Combinational filter for one line of samples across a block edge.
// Depends on hdlf_pkg for the line and result types and the threshold tables.
module hdlf_core (
  input  hdlf_pkg::line_t     line,
  input  logic signed [4:0]   alpha_adj,
  input  logic signed [4:0]   beta_adj,
  output hdlf_pkg::result_t   res
);

  function automatic logic [5:0] clip_idx(input logic signed [7:0] v);
    logic [5:0] r;
    if (v < 8'sd0) r = 6'd0;
    else if (v > 8'(hdlf_pkg::QP_MAX)) r = 6'(hdlf_pkg::QP_MAX);
    else r = v[5:0];
    return r;
  endfunction

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic signed [11:0] clip_tc(input logic signed [11:0] v,
                                                 input logic [4:0] lim);
    logic signed [11:0] hi;
    logic signed [11:0] r;
    hi = $signed({7'd0, lim});
    if (v > hi) r = hi;
    else if (v < -hi) r = -hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [7:0] sat8(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 12'sd0) r = 8'd0;
    else if (v > 12'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  function automatic logic signed [11:0] sx(input logic [7:0] v);
    return $signed({4'd0, v});
  endfunction

  function automatic logic [10:0] ux(input logic [7:0] v);
    return {3'd0, v};
  endfunction

  logic [6:0]         qp_sum;
  logic [5:0]         qp_avg;
  logic signed [7:0]  ia_raw;
  logic signed [7:0]  ib_raw;
  logic [5:0]         ia;
  logic [5:0]         ib;
  logic [7:0]         alpha;
  logic [4:0]         beta;
  logic [7:0]         d_p0q0;
  logic [7:0]         d_p1p0;
  logic [7:0]         d_q1q0;
  logic [7:0]         d_p2p0;
  logic [7:0]         d_q2q0;
  logic               edge_ok;
  logic               bs_full;
  logic               narrow;
  logic               ap;
  logic               aq;
  logic [1:0]         bs_sel;
  logic [4:0]         tc0;
  logic [4:0]         tc;
  logic [10:0]        sum_p0;
  logic [10:0]        sum_p1;
  logic [10:0]        sum_p2;
  logic [10:0]        sum_q0;
  logic [10:0]        sum_q1;
  logic [10:0]        sum_q2;
  logic [10:0]        sum_p0w;
  logic [10:0]        sum_q0w;
  logic [8:0]         avg;
  logic signed [11:0] dsum;
  logic signed [11:0] delta;
  logic signed [11:0] tp;
  logic signed [11:0] tq;
  logic signed [11:0] dp1;
  logic signed [11:0] dq1;

  always_comb begin
    qp_sum = {1'b0, line.qp_p} + {1'b0, line.qp_q} + 7'd1;
    qp_avg = qp_sum[6:1];
    ia_raw = $signed({2'b00, qp_avg}) + {{3{alpha_adj[4]}}, alpha_adj};
    ib_raw = $signed({2'b00, qp_avg}) + {{3{beta_adj[4]}}, beta_adj};
    ia = clip_idx(ia_raw);
    ib = clip_idx(ib_raw);
    alpha = hdlf_pkg::ALPHA_TAB[ia];
    beta = hdlf_pkg::BETA_TAB[ib];

    d_p0q0 = absd(line.p0, line.q0);
    d_p1p0 = absd(line.p1, line.p0);
    d_q1q0 = absd(line.q1, line.q0);
    d_p2p0 = absd(line.p2, line.p0);
    d_q2q0 = absd(line.q2, line.q0);

    edge_ok = (line.bs != 3'd0) && (alpha != 8'd0) && (beta != 5'd0) &&
              (d_p0q0 < alpha) && (d_p1p0 < {3'd0, beta}) && (d_q1q0 < {3'd0, beta});
    bs_full = line.bs >= 3'(hdlf_pkg::BS_STRONG);
    narrow = {1'b0, d_p0q0} < ({3'd0, alpha[7:2]} + 9'd2);
    ap = d_p2p0 < {3'd0, beta};
    aq = d_q2q0 < {3'd0, beta};

    sum_p0 = ux(line.p2) + (ux(line.p1) << 1) + (ux(line.p0) << 1) + (ux(line.q0) << 1)
           + ux(line.q1) + 11'd4;
    sum_p1 = ux(line.p2) + ux(line.p1) + ux(line.p0) + ux(line.q0) + 11'd2;
    sum_p2 = (ux(line.p3) << 1) + ux(line.p2) * 11'd3 + ux(line.p1) + ux(line.p0)
           + ux(line.q0) + 11'd4;
    sum_q0 = ux(line.q2) + (ux(line.q1) << 1) + (ux(line.q0) << 1) + (ux(line.p0) << 1)
           + ux(line.p1) + 11'd4;
    sum_q1 = ux(line.q2) + ux(line.q1) + ux(line.q0) + ux(line.p0) + 11'd2;
    sum_q2 = (ux(line.q3) << 1) + ux(line.q2) * 11'd3 + ux(line.q1) + ux(line.q0)
           + ux(line.p0) + 11'd4;
    sum_p0w = (ux(line.p1) << 1) + ux(line.p0) + ux(line.q1) + 11'd2;
    sum_q0w = (ux(line.q1) << 1) + ux(line.q0) + ux(line.p1) + 11'd2;

    bs_sel = line.bs[1:0] - 2'd1;
    tc0 = (line.bs[1:0] == 2'd0) ? 5'd0 : hdlf_pkg::TC0_TAB[ia][bs_sel];
    if (line.is_chroma) tc = tc0 + 5'd1;
    else tc = tc0 + {4'd0, ap} + {4'd0, aq};

    avg = ({1'b0, line.p0} + {1'b0, line.q0} + 9'd1);
    tp = sx(line.p2) + $signed({4'd0, avg[8:1]}) - (sx(line.p1) <<< 1);
    tq = sx(line.q2) + $signed({4'd0, avg[8:1]}) - (sx(line.q1) <<< 1);
    dp1 = clip_tc(tp >>> 1, tc0);
    dq1 = clip_tc(tq >>> 1, tc0);
    dsum = ((sx(line.q0) - sx(line.p0)) <<< 2) + (sx(line.p1) - sx(line.q1)) + 12'sd4;
    delta = clip_tc(dsum >>> 3, tc);

    res.p2 = line.p2;
    res.p1 = line.p1;
    res.p0 = line.p0;
    res.q0 = line.q0;
    res.q1 = line.q1;
    res.q2 = line.q2;
    res.filtered = edge_ok;

    if (edge_ok) begin
      if (bs_full) begin
        if (line.is_chroma) begin
          res.p0 = sum_p0w[9:2];
          res.q0 = sum_q0w[9:2];
        end else begin
          if (ap && narrow) begin
            res.p0 = sum_p0[10:3];
            res.p1 = sum_p1[9:2];
            res.p2 = sum_p2[10:3];
          end else begin
            res.p0 = sum_p0w[9:2];
          end
          if (aq && narrow) begin
            res.q0 = sum_q0[10:3];
            res.q1 = sum_q1[9:2];
            res.q2 = sum_q2[10:3];
          end else begin
            res.q0 = sum_q0w[9:2];
          end
        end
      end else begin
        res.p0 = sat8(sx(line.p0) + delta);
        res.q0 = sat8(sx(line.q0) - delta);
        if (!line.is_chroma && ap) res.p1 = sat8(sx(line.p1) + dp1);
        if (!line.is_chroma && aq) res.q1 = sat8(sx(line.q1) + dq1);
      end
    end
  end

endmodule

>>> design/h264_deblock_line_filter.sv
// Top level of the H.264 deblocking line filter: handshake, input and result
// registers, and the offset registers. Depends on hdlf_pkg and hdlf_core.

// The block takes one line of eight samples per clock while in_ready is high and
// returns one result word per line, in order. A line is held in the input register
// while the filter logic works on it, and its result is loaded into the output
// register, with out_valid set, once that register is empty or being taken. While a
// result waits for out_ready the block accepts one more line into the input
// register and then holds in_ready low until the output drains. The offsets are
// written through cfg_we, cfg_index and cfg_data and should only change while no
// line is in flight.
module h264_deblock_line_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] p3_in,
  input  logic [7:0] p2_in,
  input  logic [7:0] p1_in,
  input  logic [7:0] p0_in,
  input  logic [7:0] q0_in,
  input  logic [7:0] q1_in,
  input  logic [7:0] q2_in,
  input  logic [7:0] q3_in,
  input  logic [2:0] bs,
  input  logic [5:0] qp_p,
  input  logic [5:0] qp_q,
  input  logic       is_chroma,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] p2_out,
  output logic [7:0] p1_out,
  output logic [7:0] p0_out,
  output logic [7:0] q0_out,
  output logic [7:0] q1_out,
  output logic [7:0] q2_out,
  output logic       filtered
);

  logic signed [4:0]   alpha_adj;
  logic signed [4:0]   beta_adj;
  hdlf_pkg::line_t     in_word;
  hdlf_pkg::line_t     stg;
  logic                stg_valid;
  hdlf_pkg::result_t   res;
  hdlf_pkg::result_t   out_r;
  logic                out_load;

  assign in_word = '{p3: p3_in, p2: p2_in, p1: p1_in, p0: p0_in,
                     q0: q0_in, q1: q1_in, q2: q2_in, q3: q3_in,
                     bs: bs, qp_p: qp_p, qp_q: qp_q, is_chroma: is_chroma};

  assign out_load = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || out_load;

  hdlf_core u_core (
    .line      (stg),
    .alpha_adj (alpha_adj),
    .beta_adj  (beta_adj),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
      alpha_adj <= 5'sd0;
      beta_adj <= 5'sd0;
    end else begin
      if (in_ready) stg_valid <= in_valid;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          hdlf_pkg::CFG_ALPHA_ADJ: alpha_adj <= $signed(cfg_data);
          hdlf_pkg::CFG_BETA_ADJ:  beta_adj <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stg <= in_word;
    if (out_load) out_r <= res;
  end

  assign p2_out = out_r.p2;
  assign p1_out = out_r.p1;
  assign p0_out = out_r.p0;
  assign q0_out = out_r.q0;
  assign q1_out = out_r.q1;
  assign q2_out = out_r.q2;
  assign filtered = out_r.filtered;

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> stg_valid)
    else $error("Accepted word did not reach the input register.");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stg_valid && out_valid && !out_ready)
    else $error("Input stalled without a full pipeline.");

  a_stalled_word_holds: assert property (@(posedge clk) disable iff (rst)
    stg_valid && out_valid && !out_ready |=> stg_valid && $stable(stg))
    else $error("Input register changed while the output stalled.");

  a_no_bs_no_filter: assert property (@(posedge clk) disable iff (rst)
    stg_valid && stg.bs == 3'd0 |-> !res.filtered)
    else $error("Line with zero strength was filtered.");

  a_chroma_outer_kept: assert property (@(posedge clk) disable iff (rst)
    stg_valid && stg.is_chroma |-> res.p1 == stg.p1 && res.q1 == stg.q1 &&
                                   res.p2 == stg.p2 && res.q2 == stg.q2)
    else $error("Chroma line changed a sample other than p0 or q0.");

endmodule
